// ===== rtl/pgh_pkg.sv =====
// Shared types and constants of the prefetch global history table.
package pgh_pkg;

	// Operation codes on the func field
	localparam logic FUNC_LOOKUP = 1'b0;
	localparam logic FUNC_UPDATE = 1'b1;

	// Field widths
	localparam int unsigned OFF_W   = 6;
	localparam int unsigned SIG_W   = 12;
	localparam int unsigned CONF_W  = 7;
	localparam int unsigned DELTA_W = 7;
	localparam int unsigned WAY_W   = 3;

	// Highest confidence; entries at this level are never replaced
	localparam logic [CONF_W-1:0] CONF_MAX = 7'd100;

	// Controller to datapath commands
	typedef struct packed {
		logic load;    // capture a new input beat, restart the scan
		logic scan;    // examine the current entry, advance the index
		logic finish;  // write the table and load the output register
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic scan_last; // the scan index sits on the last entry
	} status_t;

endpackage

// ===== rtl/pgh_ctrl.sv =====
// Controller of the prefetch global history table: sequences capture, scan and finish.
module pgh_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output pgh_pkg::cmd_t    cmd,
	input  pgh_pkg::status_t status
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_FINISH = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       slot_free;

	// Output slot is free when empty or being drained this cycle
	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// Next state and commands
	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.scan   = 1'b0;
		cmd.finish = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (status.scan_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (slot_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/pgh_dpath.sv =====
// Datapath of the prefetch global history table: entry storage, scan trackers, result register.
module pgh_dpath #(
	parameter int unsigned ENTRIES = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pgh_pkg::cmd_t                       cmd,
	output pgh_pkg::status_t                    status,
	input  logic                                func,
	input  logic [pgh_pkg::OFF_W-1:0]           blk_offset,
	input  logic [pgh_pkg::SIG_W-1:0]           signature,
	input  logic [pgh_pkg::CONF_W-1:0]          conf_in,
	input  logic signed [pgh_pkg::DELTA_W-1:0]  delta_in,
	output logic                                hit,
	output logic [pgh_pkg::WAY_W-1:0]           way,
	output logic                                dropped,
	output logic [pgh_pkg::SIG_W-1:0]           found_sig,
	output logic [pgh_pkg::CONF_W-1:0]          found_conf,
	output logic signed [pgh_pkg::DELTA_W-1:0]  found_delta
);

	localparam int unsigned IW = $clog2(ENTRIES);
	localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

	// Entry storage
	logic                          valid_q [ENTRIES];
	logic [pgh_pkg::CONF_W-1:0]    conf_q  [ENTRIES];
	logic [pgh_pkg::SIG_W-1:0]     sig_q   [ENTRIES];
	logic [pgh_pkg::OFF_W-1:0]     off_q   [ENTRIES];
	logic [pgh_pkg::DELTA_W-1:0]   delta_q [ENTRIES];

	// Captured request
	logic                          func_q;
	logic [pgh_pkg::OFF_W-1:0]     req_off_q;
	logic [pgh_pkg::SIG_W-1:0]     req_sig_q;
	logic [pgh_pkg::CONF_W-1:0]    req_conf_q;
	logic [pgh_pkg::DELTA_W-1:0]   req_delta_q;

	// Scan trackers
	logic [IW-1:0]                 idx_q;
	logic                          found_q;
	logic [IW-1:0]                 match_way_q;
	logic [pgh_pkg::CONF_W-1:0]    best_q;
	logic [pgh_pkg::SIG_W-1:0]     best_sig_q;
	logic [pgh_pkg::DELTA_W-1:0]   best_delta_q;
	logic                          vic_ok_q;
	logic [IW-1:0]                 vic_way_q;
	logic [pgh_pkg::CONF_W-1:0]    min_q;

	// Entry under scan
	logic                          e_valid;
	logic [pgh_pkg::CONF_W-1:0]    e_conf;
	logic [pgh_pkg::SIG_W-1:0]     e_sig;
	logic [pgh_pkg::OFF_W-1:0]     e_off;
	logic [pgh_pkg::DELTA_W-1:0]   e_delta;
	logic                          e_match;

	// Table write and result
	logic                          wr_en;
	logic                          wr_alloc;
	logic [IW-1:0]                 wr_idx;
	logic                          res_hit;
	logic                          res_dropped;
	logic [IW-1:0]                 res_idx;
	logic [IW+pgh_pkg::WAY_W-1:0]  res_idx_ext;

	logic [pgh_pkg::CONF_W-1:0]    conf_sat;

	// Output register
	logic                          hit_q;
	logic [pgh_pkg::WAY_W-1:0]     way_q;
	logic                          dropped_q;
	logic [pgh_pkg::SIG_W-1:0]     fsig_q;
	logic [pgh_pkg::CONF_W-1:0]    fconf_q;
	logic [pgh_pkg::DELTA_W-1:0]   fdelta_q;

	assign status.scan_last = (idx_q == LAST_IDX);

	assign conf_sat = (conf_in > pgh_pkg::CONF_MAX) ? pgh_pkg::CONF_MAX : conf_in;

	assign e_valid = valid_q[idx_q];
	assign e_conf  = conf_q[idx_q];
	assign e_sig   = sig_q[idx_q];
	assign e_off   = off_q[idx_q];
	assign e_delta = delta_q[idx_q];
	assign e_match = (e_off == req_off_q);

	// Capture the request and walk the entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.load) begin
			idx_q <= '0;
		end else if (cmd.scan && !status.scan_last) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q       <= func;
			req_off_q    <= blk_offset;
			req_sig_q    <= signature;
			req_conf_q   <= conf_sat;
			req_delta_q  <= delta_in;
			found_q      <= 1'b0;
			match_way_q  <= '0;
			best_q       <= '0;
			best_sig_q   <= '0;
			best_delta_q <= '0;
			vic_ok_q     <= 1'b0;
			vic_way_q    <= '0;
			min_q        <= pgh_pkg::CONF_MAX;
		end else if (cmd.scan) begin
			if (func_q == pgh_pkg::FUNC_LOOKUP) begin
				// Keep the strongest match; ties keep the lower index
				if (e_match && (e_conf > best_q)) begin
					found_q      <= 1'b1;
					match_way_q  <= idx_q;
					best_q       <= e_conf;
					best_sig_q   <= e_sig;
					best_delta_q <= e_delta;
				end
			end else if (!found_q) begin
				// First valid entry with the same offset wins, else track the weakest
				if (e_valid && e_match) begin
					found_q     <= 1'b1;
					match_way_q <= idx_q;
				end else if (e_conf < min_q) begin
					vic_ok_q  <= 1'b1;
					vic_way_q <= idx_q;
					min_q     <= e_conf;
				end
			end
		end
	end

	// Decide the table write and the result
	always_comb begin
		wr_en       = 1'b0;
		wr_alloc    = 1'b0;
		wr_idx      = match_way_q;
		res_hit     = found_q;
		res_dropped = 1'b0;
		res_idx     = found_q ? match_way_q : '0;
		if (func_q == pgh_pkg::FUNC_UPDATE) begin
			if (found_q) begin
				wr_en = 1'b1;
			end else if (vic_ok_q) begin
				wr_en    = 1'b1;
				wr_alloc = 1'b1;
				wr_idx   = vic_way_q;
				res_idx  = vic_way_q;
			end else begin
				res_dropped = 1'b1;
			end
		end
	end

	assign res_idx_ext = (IW + pgh_pkg::WAY_W)'(res_idx);

	// Update entries; valid and confidence clear at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				valid_q[i] <= 1'b0;
				conf_q[i]  <= '0;
			end
		end else if (cmd.finish && wr_en) begin
			conf_q[wr_idx] <= req_conf_q;
			if (wr_alloc) begin
				valid_q[wr_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish && wr_en) begin
			sig_q[wr_idx]   <= req_sig_q;
			delta_q[wr_idx] <= req_delta_q;
			if (wr_alloc) begin
				off_q[wr_idx] <= req_off_q;
			end
		end
	end

	// Load the output register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			hit_q     <= res_hit;
			way_q     <= res_idx_ext[pgh_pkg::WAY_W-1:0];
			dropped_q <= res_dropped;
			if (func_q == pgh_pkg::FUNC_LOOKUP) begin
				fsig_q   <= best_sig_q;
				fconf_q  <= best_q;
				fdelta_q <= best_delta_q;
			end else begin
				fsig_q   <= '0;
				fconf_q  <= '0;
				fdelta_q <= '0;
			end
		end
	end

	assign hit         = hit_q;
	assign way         = way_q;
	assign dropped     = dropped_q;
	assign found_sig   = fsig_q;
	assign found_conf  = fconf_q;
	assign found_delta = fdelta_q;

endmodule

// ===== rtl/prefetch_global_history_table.sv =====
// Top level of the prefetch global history table of a signature path prefetcher.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one request beat: func selects a
//   lookup by blk_offset or an update that refreshes or inserts an entry with
//   signature, conf_in (saturated to 100) and delta_in.
//   Output channel (out_valid/out_ready) returns exactly one result beat per
//   request: hit, way, dropped and, for a lookup, the found entry's fields.
// Sequence:
//   A request is captured at the accepting edge, then the shared compare
//   unit walks the table entry by entry, and a finish step writes the entry
//   and loads the output register. A new request is accepted only in the
//   idle state after that finish step, never while one is being scanned.
// Reset:
//   arst_n clears all valid bits and confidences; the table reads as empty.
// Stall:
//   A held result stays in the output register while the next request is
//   accepted and scanned; that request waits in its final cycle until the
//   output register is taken.
module prefetch_global_history_table #(
	parameter int unsigned ENTRIES = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                func,
	input  logic [pgh_pkg::OFF_W-1:0]           blk_offset,
	input  logic [pgh_pkg::SIG_W-1:0]           signature,
	input  logic [pgh_pkg::CONF_W-1:0]          conf_in,
	input  logic signed [pgh_pkg::DELTA_W-1:0]  delta_in,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                hit,
	output logic [pgh_pkg::WAY_W-1:0]           way,
	output logic                                dropped,
	output logic [pgh_pkg::SIG_W-1:0]           found_sig,
	output logic [pgh_pkg::CONF_W-1:0]          found_conf,
	output logic signed [pgh_pkg::DELTA_W-1:0]  found_delta
);

	pgh_pkg::cmd_t    cmd;
	pgh_pkg::status_t status;

	// Sequence each beat
	pgh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.status    (status)
	);

	// Store entries and form results
	pgh_dpath #(
		.ENTRIES (ENTRIES)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.func        (func),
		.blk_offset  (blk_offset),
		.signature   (signature),
		.conf_in     (conf_in),
		.delta_in    (delta_in),
		.hit         (hit),
		.way         (way),
		.dropped     (dropped),
		.found_sig   (found_sig),
		.found_conf  (found_conf),
		.found_delta (found_delta)
	);

endmodule

// ===== sim/pgh_history_checker.sv =====
// Reply predictor and checker for the prefetch global history table.
module pgh_history_checker
	import pgh_pkg::*;
#(
	parameter int unsigned ENTRIES = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic                      func,
	input  logic [OFF_W-1:0]          blk_offset,
	input  logic [SIG_W-1:0]          signature,
	input  logic [CONF_W-1:0]         conf_in,
	input  logic signed [DELTA_W-1:0] delta_in,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic                      hit,
	input  logic [WAY_W-1:0]          way,
	input  logic                      dropped,
	input  logic [SIG_W-1:0]          found_sig,
	input  logic [CONF_W-1:0]         found_conf,
	input  logic signed [DELTA_W-1:0] found_delta,
	output int unsigned               fail_count,
	output int unsigned               in_flight
);

	typedef struct packed {
		logic               hit;
		logic [WAY_W-1:0]   way;
		logic               dropped;
		logic [SIG_W-1:0]   sig;
		logic [CONF_W-1:0]  conf;
		logic [DELTA_W-1:0] delta;
	} reply_t;

	// Shadow copy of the history table
	logic               gh_valid  [ENTRIES];
	logic [SIG_W-1:0]   gh_sig    [ENTRIES];
	logic [CONF_W-1:0]  gh_conf   [ENTRIES];
	logic [OFF_W-1:0]   gh_offset [ENTRIES];
	logic [DELTA_W-1:0] gh_delta  [ENTRIES];

	reply_t replies_due [$];
	reply_t want;

	// Start from the empty table
	initial begin
		fail_count = 0;
		in_flight  = 0;
		for (int i = 0; i < ENTRIES; i++) begin
			gh_valid[i]  = 1'b0;
			gh_sig[i]    = '0;
			gh_conf[i]   = '0;
			gh_offset[i] = '0;
			gh_delta[i]  = '0;
		end
	end

	// Apply one request to the shadow table and work out its reply
	task automatic access_history(input logic op, input logic [OFF_W-1:0] off,
		input logic [SIG_W-1:0] sig, input logic [CONF_W-1:0] conf,
		input logic [DELTA_W-1:0] dlt, output reply_t r);
		int best;
		int best_way;
		int weakest;
		int victim;
		bit done;
		int i;
		logic [CONF_W-1:0] conf_sat;
		r = '0;
		if (op == FUNC_LOOKUP) begin
			// Highest nonzero confidence wins, lowest index on a tie
			best = 0;
			best_way = -1;
			for (i = 0; i < ENTRIES; i++) begin
				if (gh_offset[i] == off && best < int'(gh_conf[i])) begin
					best = int'(gh_conf[i]);
					best_way = i;
				end
			end
			if (best_way >= 0) begin
				r.hit   = 1'b1;
				r.way   = best_way[WAY_W-1:0];
				r.sig   = gh_sig[best_way];
				r.conf  = gh_conf[best_way];
				r.delta = gh_delta[best_way];
			end
		end else begin
			conf_sat = (conf > CONF_MAX) ? CONF_MAX : conf;
			weakest = int'(CONF_MAX);
			victim = -1;
			done = 1'b0;
			// Refresh the first valid entry on this offset, else track the weakest
			for (i = 0; i < ENTRIES && !done; i++) begin
				if (gh_valid[i] && gh_offset[i] == off) begin
					gh_sig[i]   = sig;
					gh_conf[i]  = conf_sat;
					gh_delta[i] = dlt;
					r.hit = 1'b1;
					r.way = i[WAY_W-1:0];
					done = 1'b1;
				end else if (int'(gh_conf[i]) < weakest) begin
					weakest = int'(gh_conf[i]);
					victim = i;
				end
			end
			if (!done) begin
				if (victim >= 0) begin
					gh_valid[victim]  = 1'b1;
					gh_sig[victim]    = sig;
					gh_conf[victim]   = conf_sat;
					gh_offset[victim] = off;
					gh_delta[victim]  = dlt;
					r.way = victim[WAY_W-1:0];
				end else begin
					r.dropped = 1'b1;
				end
			end
		end
	endtask

	task automatic check_field(input string name, input int expd, input int actl);
		if (expd != actl) begin
			$display("%0t: reply field %s expected %0d actual %0d", $time, name, expd, actl);
			fail_count++;
		end
	endtask

	// Retire reply beats against the oldest prediction, then log new requests
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (replies_due.size() == 0) begin
					$display("%0t: reply beat with none expected, hit %0d way %0d dropped %0d",
						$time, hit, way, dropped);
					fail_count++;
				end else begin
					want = replies_due.pop_front();
					check_field("hit", int'(want.hit), int'(hit));
					check_field("way", int'(want.way), int'(way));
					check_field("dropped", int'(want.dropped), int'(dropped));
					check_field("found_sig", int'(want.sig), int'(found_sig));
					check_field("found_conf", int'(want.conf), int'(found_conf));
					check_field("found_delta", int'($signed(want.delta)), int'(found_delta));
				end
			end
			if (in_valid && in_ready) begin
				access_history(func, blk_offset, signature, conf_in, delta_in, want);
				replies_due.push_back(want);
			end
			in_flight = replies_due.size();
		end
	end

endmodule

// ===== sim/prefetch_global_history_table_tb.sv =====
// Testbench top for the prefetch global history table: stimulus, idling and verdict.
module prefetch_global_history_table_tb;
	import pgh_pkg::*;

	localparam int unsigned TABLE_SIZE      = 8;
	localparam int unsigned RANDOM_REQUESTS = 1350;
	localparam int unsigned CYCLE_LIMIT     = 400000;
	localparam int unsigned SETTLE_CYCLES   = TABLE_SIZE + 6;

	logic                      clk;
	logic                      arst_n      = 1'b0;
	logic                      in_valid    = 1'b0;
	logic                      func        = FUNC_LOOKUP;
	logic [OFF_W-1:0]          blk_offset  = '0;
	logic [SIG_W-1:0]          signature   = '0;
	logic [CONF_W-1:0]         conf_in     = '0;
	logic signed [DELTA_W-1:0] delta_in    = '0;
	logic                      out_ready   = 1'b0;
	logic                      in_ready;
	logic                      out_valid;
	logic                      hit;
	logic [WAY_W-1:0]          way;
	logic                      dropped;
	logic [SIG_W-1:0]          found_sig;
	logic [CONF_W-1:0]         found_conf;
	logic signed [DELTA_W-1:0] found_delta;

	int unsigned fail_count;
	int unsigned in_flight;
	int unsigned cycles     = 0;
	int unsigned stall_left = 0;
	bit          calm       = 1'b0;

	prefetch_global_history_table #(
		.ENTRIES(TABLE_SIZE)
	) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .blk_offset(blk_offset), .signature(signature),
		.conf_in(conf_in), .delta_in(delta_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.hit(hit), .way(way), .dropped(dropped),
		.found_sig(found_sig), .found_conf(found_conf), .found_delta(found_delta)
	);

	pgh_history_checker #(
		.ENTRIES(TABLE_SIZE)
	) u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .blk_offset(blk_offset), .signature(signature),
		.conf_in(conf_in), .delta_in(delta_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.hit(hit), .way(way), .dropped(dropped),
		.found_sig(found_sig), .found_conf(found_conf), .found_delta(found_delta),
		.fail_count(fail_count), .in_flight(in_flight)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Stall the reply side in random bursts; no new burst starts during the calm stretch
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (!calm && $urandom_range(999) < 10) begin
			stall_left <= $urandom_range(1, 16);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Present one request beat and hold it until accepted
	task automatic send_request(input logic op, input logic [OFF_W-1:0] off,
		input logic [SIG_W-1:0] sig, input logic [CONF_W-1:0] conf,
		input logic [DELTA_W-1:0] dlt);
		in_valid    <= 1'b1;
		func        <= op;
		blk_offset  <= off;
		signature   <= sig;
		conf_in     <= conf;
		delta_in    <= dlt;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
	endtask

	// Hold off the sender until every reply has come back
	task automatic drain_replies();
		in_valid <= 1'b0;
		do @(negedge clk); while (in_flight != 0);
		@(posedge clk);
	endtask

	initial begin
		logic              op;
		logic [OFF_W-1:0]  off;
		logic [SIG_W-1:0]  sig;
		logic [CONF_W-1:0] conf;
		logic [DELTA_W-1:0] dlt;
		int unsigned       pick;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table: offset zero matches only entries of zero confidence
		send_request(FUNC_LOOKUP, 6'd0, 12'h000, 7'd0, 7'd0);
		// Saturate confidence, store the out-of-range delta pattern
		send_request(FUNC_UPDATE, 6'd5, 12'hfff, 7'd127, 7'h40);
		send_request(FUNC_LOOKUP, 6'd5, 12'h000, 7'd0, 7'd0);
		// Zero-confidence entry is valid yet invisible to lookups
		send_request(FUNC_UPDATE, 6'd63, 12'h000, 7'd0, 7'sd63);
		send_request(FUNC_LOOKUP, 6'd63, 12'hfff, 7'd127, 7'h7f);
		// Refresh it in place
		send_request(FUNC_UPDATE, 6'd63, 12'habc, 7'd50, -7'sd63);
		send_request(FUNC_LOOKUP, 6'd63, 12'h000, 7'd0, 7'd0);
		send_request(FUNC_UPDATE, 6'd0, 12'h123, 7'd101, -7'sd1);
		// Fill the rest at full confidence
		for (int i = 10; i < 15; i++)
			send_request(FUNC_UPDATE, i[OFF_W-1:0], 12'h555, CONF_MAX, 7'sd7);
		// Replace the only weak entry, then find no victim at all
		send_request(FUNC_UPDATE, 6'd20, 12'h2aa, CONF_MAX, -7'sd8);
		send_request(FUNC_UPDATE, 6'd30, 12'h777, CONF_MAX, 7'sd3);
		send_request(FUNC_LOOKUP, 6'd30, 12'h000, 7'd0, 7'd0);
		// Refresh a full-confidence entry to a lower level, then evict it
		send_request(FUNC_UPDATE, 6'd5, 12'h0f0, 7'd40, 7'sd1);
		send_request(FUNC_LOOKUP, 6'd5, 12'h000, 7'd0, 7'd0);
		send_request(FUNC_UPDATE, 6'd33, 12'h00f, 7'd99, -7'sd32);
		send_request(FUNC_LOOKUP, 6'd12, 12'h000, 7'd0, 7'd0);
		send_request(FUNC_LOOKUP, 6'd0, 12'h000, 7'd0, 7'd0);
		drain_replies();

		// Random traffic on a narrow offset pool so entries collide and refresh
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			calm = (n >= 400 && n < 650);
			if (n == 700)
				drain_replies();
			if (!calm && $urandom_range(99) < 25) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			op  = $urandom_range(1) ? FUNC_UPDATE : FUNC_LOOKUP;
			off = ($urandom_range(99) < 80) ? 6'($urandom_range(11)) : 6'($urandom_range(63));
			sig = 12'($urandom_range(4095));
			pick = $urandom_range(99);
			if (pick < 35)
				conf = CONF_MAX;
			else if (pick < 45)
				conf = 7'd0;
			else if (pick < 50)
				conf = 7'($urandom_range(127, 101));
			else
				conf = 7'($urandom_range(99, 1));
			dlt = ($urandom_range(99) < 5) ? 7'h40 : 7'($signed($urandom_range(126)) - 63);
			send_request(op, off, sig, conf, dlt);
		end
		calm = 1'b0;
		drain_replies();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (fail_count == 0 && in_flight == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
